// File: rtl/core/fsc_pkg.sv
// Shared types, constants and helper functions for the frustum sphere cull block.
package fsc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int FIFO_DEPTH  = 2;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 48;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic       is_test;
        logic [1:0] row;
        t_word      e0;
        t_word      e1;
        t_word      e2;
        t_word      e3;
    } t_item;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_COPY
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SQ,
        ST_SQRT,
        ST_LENCHK,
        ST_DIVINIT,
        ST_DIV,
        ST_DIVWR,
        ST_TMAC,
        ST_TCMP,
        ST_OUT
    } t_state;

    function automatic t_op plane_op(input logic [2:0] p);
        t_op op;
        case (p)
            3'd0, 3'd2: op = OP_ADD;
            3'd4:       op = OP_COPY;
            default:    op = OP_SUB;
        endcase
        return op;
    endfunction

    function automatic logic [1:0] plane_col(input logic [2:0] p);
        logic [1:0] c;
        case (p)
            3'd0, 3'd1: c = 2'd0;
            3'd2, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic t_word sat33(input logic signed [32:0] v);
        t_word r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input t_word v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return m;
    endfunction

endpackage

// File: rtl/core/frustum_sphere_cull_top.sv
// Top level of the frustum sphere cull block: front queue and plane/test back end.
//
// Input channel (i_s_*): one transaction is a load or a test, selected by
// i_s_tuser (0 = load one matrix row, 1 = test one sphere). A load writes
// row row_index of the Q16.16 view-projection matrix and rebuilds all six
// planes; it returns nothing. A test returns one transaction on the output
// channel (o_m_*) whose bit 0 is 1 when the sphere is visible.
// A test works plane by plane on the shared multiplier (3 products and a
// compare per plane) and stops early when a plane culls it. A load runs
// the bit-serial square root and the bit-serial divider (one division per
// component, four components per plane, six planes).
// A two-entry queue takes new transactions while the back end works, and a
// result register holds a finished result while the next item proceeds.
// Reset: the matrix and planes clear to zero, queue and result empty.
// When the receiver stalls, hold the result; the back end stops only when
// it has a further result to hand over.
module frustum_sphere_cull_top
    import fsc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,  // row_index[1:0], elem0..elem3 from bit 2 up, zero pad
    input  logic         i_s_tuser,  // cmd
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata   // visible[0], zero pad
);

    t_item w_item;
    logic  w_valid;
    logic  w_pop;

    fsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_valid    (w_valid),
        .o_item     (w_item),
        .i_pop      (w_pop)
    );

    fsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// File: rtl/core/fsc_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module fsc_front
    import fsc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic         i_s_tuser,
    output logic         o_valid,
    output t_item        o_item,
    input  logic         i_pop
);

    t_item      r_mem [FIFO_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    // classify: tuser carries the kind, tdata the row and the four words
    always_comb begin
        w_item.is_test = i_s_tuser;
        w_item.row     = i_s_tdata[1:0];
        w_item.e0      = i_s_tdata[33:2];
        w_item.e1      = i_s_tdata[65:34];
        w_item.e2      = i_s_tdata[97:66];
        w_item.e3      = i_s_tdata[129:98];
    end

    assign o_s_tready = (r_cnt != 2'(FIFO_DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/core/fsc_back.sv
// Back end: plane rebuild (square, root, divide) and sphere test on one shared multiplier.
module fsc_back
    import fsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata
);

    t_state r_state;
    t_state n_state;

    t_word  r_mat [4][4];
    t_word  r_pl  [PLANE_COUNT][4];

    logic [2:0]          r_p;
    logic [1:0]          r_k;
    logic [5:0]          r_cnt;
    t_item               r_item;
    logic signed [63:0]  r_prod;
    logic [63:0]         r_s;
    logic [63:0]         r_root;
    logic [63:0]         r_bit;
    logic [31:0]         r_len;
    logic [47:0]         r_num;
    logic [31:0]         r_rem;
    logic [47:0]         r_q;
    logic signed [49:0]  r_acc;
    logic                r_cull;
    logic                r_out_valid;
    logic                r_out_vis;

    logic                w_out_free;
    logic                w_res_load;
    logic signed [32:0]  w_mul_a;
    logic signed [32:0]  w_mul_b;
    logic signed [65:0]  w_mul_p;
    logic [63:0]         w_sq_t;
    logic                w_sq_ge;
    logic [32:0]         w_dv_t;
    logic                w_dv_ge;
    t_word               w_cur;
    t_word               w_norm;
    logic [47:0]         w_qs;
    t_word               w_ds;
    logic signed [33:0]  w_margin;
    logic                w_last_plane;

    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_cur        = r_pl[r_p][r_k];
    assign w_last_plane = (r_p == 3'(PLANE_COUNT - 1));

    // shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_SQ: begin
                w_mul_a = {1'b0, mag32(w_cur)};
                w_mul_b = {1'b0, mag32(w_cur)};
            end
            ST_TMAC: begin
                w_mul_a = {w_cur[31], w_cur};
                case (r_k)
                    2'd0:    w_mul_b = {r_item.e0[31], r_item.e0};
                    2'd1:    w_mul_b = {r_item.e1[31], r_item.e1};
                    2'd2:    w_mul_b = {r_item.e2[31], r_item.e2};
                    default: w_mul_b = '0;
                endcase
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // root and divide steps
    assign w_sq_t  = r_root + r_bit;
    assign w_sq_ge = (r_s >= w_sq_t);
    assign w_dv_t  = {r_rem, r_num[47]};
    assign w_dv_ge = (w_dv_t >= {1'b0, r_len});

    // sign restore and saturate the quotient
    always_comb begin
        if (w_cur[31]) begin
            w_qs   = (r_q > 48'h0000_8000_0000) ? 48'h0000_8000_0000 : r_q;
            w_norm = ~w_qs[31:0] + 32'd1;
        end else begin
            w_norm = (r_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : r_q[31:0];
            w_qs   = r_q;
        end
    end

    // saturated distance against the radius
    always_comb begin
        if (r_acc > 50'sh7FFF_FFFF) begin
            w_ds = 32'sh7FFF_FFFF;
        end else if (r_acc < -50'sh8000_0000) begin
            w_ds = 32'sh8000_0000;
        end else begin
            w_ds = r_acc[31:0];
        end
        w_margin = {{2{w_ds[31]}}, w_ds} + {{2{r_item.e3[31]}}, r_item.e3};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_item.is_test ? ST_TMAC : ST_BUILD;
                end
            end
            ST_BUILD:   n_state = ST_SQ;
            ST_SQ:      n_state = (r_k == 2'd3) ? ST_SQRT : ST_SQ;
            ST_SQRT:    n_state = (r_cnt == 6'(SQRT_STEPS - 1)) ? ST_LENCHK : ST_SQRT;
            ST_LENCHK: begin
                if (r_root != 64'd0) begin
                    n_state = ST_DIVINIT;
                end else begin
                    n_state = w_last_plane ? ST_IDLE : ST_BUILD;
                end
            end
            ST_DIVINIT: n_state = ST_DIV;
            ST_DIV:     n_state = (r_cnt == 6'(DIV_STEPS - 1)) ? ST_DIVWR : ST_DIV;
            ST_DIVWR: begin
                if (r_k != 2'd3) begin
                    n_state = ST_DIVINIT;
                end else begin
                    n_state = w_last_plane ? ST_IDLE : ST_BUILD;
                end
            end
            ST_TMAC:    n_state = (r_k == 2'd3) ? ST_TCMP : ST_TMAC;
            ST_TCMP: begin
                if (w_margin[33] || w_last_plane) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_TMAC;
                end
            end
            ST_OUT:     n_state = w_out_free ? ST_IDLE : ST_OUT;
            default:    n_state = ST_IDLE;
        endcase
    end

    // strobes
    always_comb begin
        o_pop      = 1'b0;
        w_res_load = 1'b0;
        case (r_state)
            ST_IDLE: o_pop      = i_valid;
            ST_OUT:  w_res_load = w_out_free;
            default: begin
                o_pop      = 1'b0;
                w_res_load = 1'b0;
            end
        endcase
    end

    // control and reset-cleared stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_mat[i][j] <= '0;
                end
            end
            for (int i = 0; i < PLANE_COUNT; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pl[i][j] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && i_valid && !i_item.is_test) begin
                r_mat[i_item.row][0] <= i_item.e0;
                r_mat[i_item.row][1] <= i_item.e1;
                r_mat[i_item.row][2] <= i_item.e2;
                r_mat[i_item.row][3] <= i_item.e3;
            end
            if (r_state == ST_BUILD) begin
                for (int r = 0; r < 4; r++) begin
                    case (plane_op(r_p))
                        OP_ADD:  r_pl[r_p][r] <= sat33(33'(r_mat[r][3]) +
                                                 33'(r_mat[r][plane_col(r_p)]));
                        OP_SUB:  r_pl[r_p][r] <= sat33(33'(r_mat[r][3]) -
                                                 33'(r_mat[r][plane_col(r_p)]));
                        default: r_pl[r_p][r] <= r_mat[r][plane_col(r_p)];
                    endcase
                end
            end
            if (r_state == ST_DIVWR) begin
                r_pl[r_p][r_k] <= w_norm;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_vis <= !r_cull;
        end
        case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                r_p    <= 3'd0;
                r_k    <= 2'd0;
                r_cull <= 1'b0;
            end
            ST_BUILD: begin
                r_k <= 2'd0;
            end
            ST_SQ: begin
                r_prod <= w_mul_p[63:0];
                r_k    <= r_k + 2'd1;
                if (r_k == 2'd0) begin
                    r_s <= 64'd0;
                end else begin
                    r_s <= r_s + 64'(r_prod);
                end
                r_root <= 64'd0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= 6'd0;
            end
            ST_SQRT: begin
                if (w_sq_ge) begin
                    r_s    <= r_s - w_sq_t;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
            end
            ST_LENCHK: begin
                r_len <= r_root[31:0];
                r_k   <= 2'd0;
                if (r_root == 64'd0) begin
                    r_p <= r_p + 3'd1;
                end
            end
            ST_DIVINIT: begin
                r_num <= {mag32(w_cur), 16'd0} + 48'(r_len >> 1);
                r_rem <= 32'd0;
                r_q   <= 48'd0;
                r_cnt <= 6'd0;
            end
            ST_DIV: begin
                if (w_dv_ge) begin
                    r_rem <= 32'(w_dv_t - {1'b0, r_len});
                end else begin
                    r_rem <= w_dv_t[31:0];
                end
                r_q   <= {r_q[46:0], w_dv_ge};
                r_num <= {r_num[46:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            ST_DIVWR: begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_p <= r_p + 3'd1;
                end
            end
            ST_TMAC: begin
                r_prod <= w_mul_p[63:0];
                r_k    <= r_k + 2'd1;
                if (r_k == 2'd0) begin
                    r_acc <= 50'(r_pl[r_p][3]);
                end else begin
                    r_acc <= r_acc + 50'(r_prod >>> 16);
                end
            end
            ST_TCMP: begin
                r_acc  <= r_acc + 50'(r_prod >>> 16);
                r_k    <= 2'd0;
                r_cull <= w_margin[33];
                r_p    <= r_p + 3'd1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_vis};

endmodule

// File: rtl/core/fsc_checker.sv
// Port-level checks for the frustum sphere cull block, bound to the top level.
module fsc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [135:0] i_s_tdata,
    input logic         i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [7:0]   o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result transaction dropped while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

endmodule

bind frustum_sphere_cull_top fsc_checker u_fsc_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the frustum sphere cull block.
module tb_top;
    import fsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [135:0] i_s_tdata;  // row_index[1:0], elem0..elem3 from bit 2 up, zero pad
    logic         i_s_tuser;  // cmd
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [7:0]   o_m_tdata;  // visible[0], zero pad

    frustum_sphere_cull_top u_top (.*);

    // Model state: matrix rows and normalized planes.
    t_word mat_q[16];
    t_word plane_q[24];
    bit    visible_q[$];
    int    fail_count;
    int    idle_cycles;
    bit    rx_hold;   // long receiver hold-off requested

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Integer square root of a 64-bit value, floor.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_word clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return t_word'(v);
    endfunction

    function automatic t_word scale_by_len(input t_word v, input logic [63:0] len);
        logic [63:0] m, q;
        m = v[31] ? 64'(-longint'(v)) : 64'(v);
        q = ((m << 16) + (len >> 1)) / len;
        if (v[31]) return clamp32(-longint'(q > 64'h8000_0000 ? 64'h8000_0000 : q));
        return clamp32(longint'(q > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : q));
    endfunction

    // Rebuild all planes from the current matrix.
    task automatic rebuild_planes();
        t_op         op;
        int          col;
        longint      v, base, oth;
        logic [63:0] s, m, len;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            op  = (p == 0 || p == 2) ? OP_ADD : (p == 4 ? OP_COPY : OP_SUB);
            col = p / 2;
            for (int r = 0; r < 4; r++) begin
                base = mat_q[r*4+3];
                oth  = mat_q[r*4+col];
                case (op)
                    OP_ADD:  v = base + oth;
                    OP_SUB:  v = base - oth;
                    default: v = oth;
                endcase
                plane_q[p*4+r] = clamp32(v);
            end
            s = 0;
            for (int r = 0; r < 3; r++) begin
                v = plane_q[p*4+r];
                m = v < 0 ? 64'(-v) : 64'(v);
                s += m * m;
            end
            len = floor_sqrt(s);
            if (len != 0)
                for (int r = 0; r < 4; r++) plane_q[p*4+r] = scale_by_len(plane_q[p*4+r], len);
        end
    endtask

    function automatic longint floor_q16(input longint v);
        return v >>> 16;  // arithmetic shift floors toward minus infinity
    endfunction

    function automatic bit sphere_visible(input t_word cx, cy, cz, rad);
        longint d;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            d = floor_q16(longint'(plane_q[p*4]) * cx) + floor_q16(longint'(plane_q[p*4+1]) * cy)
              + floor_q16(longint'(plane_q[p*4+2]) * cz) + longint'(plane_q[p*4+3]);
            if (longint'(clamp32(d)) < -longint'(rad)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random gap: mostly short, a few long.
    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one transaction and update the prediction when it is accepted.
    // Valid stays high after acceptance until a gap or a drain drops it.
    task automatic send_item(input bit is_test, input logic [1:0] row,
                             input t_word e0, e1, e2, e3);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= is_test;
        i_s_tdata  <= {6'd0, e3, e2, e1, e0, row};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (is_test) begin
            visible_q.push_back(sphere_visible(e0, e1, e2, e3));
        end else begin
            mat_q[row*4] = e0; mat_q[row*4+1] = e1; mat_q[row*4+2] = e2; mat_q[row*4+3] = e3;
            rebuild_planes();
        end
        @(negedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0:       return t_word'($urandom);
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            3:       return t_word'($urandom_range(0, 8)) - 4;
            default: return t_word'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
        endcase
    endfunction

    // Drop valid and hold until every expected result has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (visible_q.size() != 0);
    endtask

    // Reset planes: zero distances, only negative radii cull.
    task automatic test_reset_planes();
        send_item(1, 0, 0, 0, 0, 32'sh0001_0000);
        send_item(1, 3, 32'sh7FFF_FFFF, 32'sh8000_0000, 5, -1);
        send_item(1, 1, 0, 0, 0, 0);
        send_item(1, 2, 0, 0, 0, 32'sh8000_0000);
    endtask

    // Identity matrix, then spheres inside, outside and straddling.
    task automatic test_identity();
        send_item(0, 0, 32'sh0001_0000, 0, 0, 0);
        send_item(1, 0, 0, 0, 0, 32'sh0001_0000);   // partial matrix
        send_item(0, 1, 0, 32'sh0001_0000, 0, 0);
        send_item(0, 2, 0, 0, 32'sh0001_0000, 0);
        send_item(0, 3, 0, 0, 0, 32'sh0001_0000);
        send_item(1, 0, 0, 0, 32'sh0000_8000, 32'sh0000_1000);
        send_item(1, 0, 32'sh0005_0000, 0, 32'sh0000_8000, 32'sh0000_1000);
        send_item(1, 0, 32'sh0001_8000, 0, 32'sh0000_8000, 32'sh0001_0000);
        send_item(1, 0, 0, 0, 32'sh0000_8000, -32'sh0002_0000);
    endtask

    // Extreme rows saturate the column sums; tiny rows leave degenerate planes.
    task automatic test_extremes();
        send_item(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(0, 3, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_item(1, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(1, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        for (int r = 0; r < 4; r++) send_item(0, r[1:0], 0, 0, 0, 0);
        send_item(0, 1, 0, 0, 0, 32'sh0000_0001);
        send_item(1, 0, 5, 5, 5, 0);
        send_item(1, 0, 5, 5, 5, -3);
    endtask

    // Random loads and tests; the receiver stalls for a long stretch midway.
    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) begin
                rx_hold = 1'b1;  // receiver holds off while tests pile up
                for (int k = 0; k < 6; k++) send_item(1, 0, rand_word(), rand_word(),
                                                      rand_word(), rand_word());
            end
            if (i == n / 2) wait_drained();  // sender pause until all results are in
            if ($urandom_range(0, 9) < 2)
                send_item(0, 2'($urandom), rand_word(), rand_word(), rand_word(), rand_word());
            else
                send_item(1, 2'($urandom), rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    // Receiver: random ready with gaps, plus the requested long hold-off.
    initial begin
        int hold;
        int gap;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_m_tready <= 1'b0;
                hold = 0;
                while (hold < 400) begin
                    @(negedge i_clk);
                    hold++;
                end
                rx_hold = 1'b0;
            end else if (i_m_tready && $urandom_range(0, 3) == 0) begin
                gap = rand_gap();
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    i_m_tready <= 1'b1;
                end
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (visible_q.size() == 0) begin
                $error("visible: unexpected result, actual %0d", o_m_tdata[0]);
                fail_count++;
            end else if (o_m_tdata[0] !== visible_q[0]) begin
                $error("visible: expected %0d, actual %0d", visible_q[0], o_m_tdata[0]);
                fail_count++;
                void'(visible_q.pop_front());
            end else begin
                void'(visible_q.pop_front());
            end
        end
    end

    // Watchdog: count cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        rx_hold = 1'b0;
        foreach (mat_q[i]) mat_q[i] = 0;
        foreach (plane_q[i]) plane_q[i] = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = 1'b0;
        i_s_tdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_planes();
        test_identity();
        test_extremes();
        test_random(1000);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && visible_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: frustum_sphere_cull_top.f
rtl/core/fsc_pkg.sv
rtl/core/fsc_front.sv
rtl/core/fsc_back.sv
rtl/core/frustum_sphere_cull_top.sv
rtl/core/fsc_checker.sv
test/tb_top.sv
